// File: sv/gfa_pkg.sv
// Shared codes, widths and tag values for the guarded frame allocator.
`default_nettype none

package gfa_pkg;

  localparam int TAG_W    = 16;
  localparam int GRANT_W  = 14;
  localparam int STATUS_W = 2;
  localparam int ACTION_W = 2;

  typedef logic [TAG_W-1:0]    tag_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [ACTION_W-1:0] action_t;

  localparam action_t ACT_ALLOC = 2'd0;
  localparam action_t ACT_FREE  = 2'd1;
  localparam action_t ACT_QUERY = 2'd2;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_NONE  = 2'd1;
  localparam status_t ST_RANGE = 2'd2;

  localparam tag_t TAG_FREE   = 16'h0000;
  localparam tag_t TAG_KERNEL = 16'hFFFF;

  // A neighbour tag that may sit next to a frame given to `tag`.
  function automatic logic neighbour_ok(input tag_t t, input tag_t tag);
    neighbour_ok = (t == tag) || (t == TAG_FREE) || (t == TAG_KERNEL);
  endfunction

endpackage

`default_nettype wire

// File: sv/guarded_frame_allocator_unit.sv
// Top level of the guarded frame allocator: owner-tag memory and scan sequencer.
// Steps, from the accepting edge to the result beat: free goes straight to the load
//   state, query waits for its registered tag read, allocate scans (one tag read per
//   cycle through the single memory read port, then a check of the last frame).
// Throughput: one item at a time; the next beat is taken in the cycle after the result is
//   loaded, later while an earlier result beat is still stalled.
// Reset: the tag memory is cleared by a pass over all FRAME_COUNT entries, one entry per
//   cycle, during which no input beat is taken.
`default_nettype none

module guarded_frame_allocator_unit #(
  parameter int FRAME_COUNT = 16384
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  action,
  input  wire logic        kernel_request,
  input  wire logic [15:0] owner_id,
  input  wire logic [15:0] frame_index,
  // output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [13:0]      granted_frame,
  output logic [15:0]      owner_tag
);

  localparam int IDX_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_COUNT - 1);

  // Sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FLUSH = 3'd3;
  localparam logic [2:0] S_QWAIT = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [2:0] state, state_next;

  // Owner-tag memory: one write port, one registered read port.
  gfa_pkg::tag_t tags [FRAME_COUNT];

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  gfa_pkg::tag_t    wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  gfa_pkg::tag_t    rd_data;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_vld;

  // Request and scan registers
  logic [IDX_W-1:0] clr;           // clearing pass address
  logic [IDX_W-1:0] cnt;           // next scan read address
  logic             issue_done;    // every scan read has been issued
  gfa_pkg::tag_t    req_tag;       // tag to write on a grant
  logic             req_kernel;
  gfa_pkg::tag_t    w0, w1;        // tags of the two frames before the newest read

  // Held result, loaded into the output register in S_RESP
  gfa_pkg::status_t res_status;
  logic [13:0]      res_grant;
  gfa_pkg::tag_t    res_tag;

  logic accept;
  logic in_range;
  logic out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign in_range = ({1'b0, frame_index} < 17'(FRAME_COUNT));
  assign out_free = !out_valid || !out_stall;

  // Candidate check: the shared compare unit, fed once per cycle.
  // The candidate is the frame whose tag sits in w1; its left neighbour is w0
  // and its right neighbour is the newest read, or free past the last frame.
  logic             cand_zero;
  logic [IDX_W-1:0] cand;
  gfa_pkg::tag_t    right_tag;
  logic             hit;

  always_comb begin
    if (state == S_FLUSH) begin
      cand      = LAST_IDX;
      right_tag = gfa_pkg::TAG_FREE;
    end else begin
      cand      = rd_idx - IDX_W'(1);
      right_tag = rd_data;
    end
    cand_zero = (cand == '0);
    if (w1 != gfa_pkg::TAG_FREE) begin
      hit = 1'b0;
    end else if (cand_zero) begin
      // Frame zero only looks at frame one, and only accepts free or own tag.
      hit = (right_tag == gfa_pkg::TAG_FREE) || (right_tag == req_tag);
    end else if (req_kernel) begin
      hit = 1'b1;
    end else begin
      hit = gfa_pkg::neighbour_ok(w0, req_tag) && gfa_pkg::neighbour_ok(right_tag, req_tag);
    end
  end

  logic scan_eval;
  logic grant;
  assign scan_eval = (state == S_SCAN) && rd_vld && (rd_idx != '0);
  assign grant     = (scan_eval || (state == S_FLUSH)) && hit;

  // Memory port steering
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cand;
    wr_data = req_tag;
    rd_en   = 1'b0;
    rd_addr = cnt;
    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr;
        wr_data = gfa_pkg::TAG_FREE;
      end
      S_IDLE: begin
        wr_en   = accept && (action == gfa_pkg::ACT_FREE) && in_range;
        wr_addr = frame_index[IDX_W-1:0];
        wr_data = gfa_pkg::TAG_FREE;
        rd_en   = accept && (action == gfa_pkg::ACT_QUERY) && in_range;
        rd_addr = frame_index[IDX_W-1:0];
      end
      S_SCAN: begin
        wr_en = grant;
        rd_en = !issue_done && !grant;
      end
      S_FLUSH: begin
        wr_en = grant;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tags[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= tags[rd_addr];
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr == LAST_IDX) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (action == gfa_pkg::ACT_ALLOC) begin
            if (!kernel_request && (owner_id == gfa_pkg::TAG_FREE ||
                                    owner_id == gfa_pkg::TAG_KERNEL)) begin
              state_next = S_RESP;
            end else begin
              state_next = S_SCAN;
            end
          end else if (action == gfa_pkg::ACT_QUERY && in_range) begin
            state_next = S_QWAIT;
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_SCAN: begin
        if (grant) begin
          state_next = S_RESP;
        end else if (rd_vld && rd_idx == LAST_IDX) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: state_next = S_RESP;
      S_QWAIT: begin
        if (rd_vld) state_next = S_RESP;
      end
      S_RESP: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr        <= '0;
      rd_vld     <= 1'b0;
      out_valid  <= 1'b0;
      issue_done <= 1'b0;
      cnt        <= '0;
    end else begin
      state  <= state_next;
      rd_vld <= rd_en;
      if (state == S_CLEAR) begin
        clr <= clr + IDX_W'(1);
      end
      // Scan read address: advance until the last frame is issued.
      if (accept) begin
        cnt        <= '0;
        issue_done <= 1'b0;
      end else if (rd_en && state == S_SCAN) begin
        if (cnt == LAST_IDX) begin
          issue_done <= 1'b1;
        end else begin
          cnt <= cnt + IDX_W'(1);
        end
      end
      // Output beat: load from S_RESP, drop once taken.
      if (state == S_RESP && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_idx <= rd_addr;
    end
    if (accept) begin
      req_kernel <= kernel_request;
      req_tag    <= kernel_request ? gfa_pkg::TAG_KERNEL : owner_id;
      res_grant  <= '0;
      res_tag    <= gfa_pkg::TAG_FREE;
      if (action == gfa_pkg::ACT_ALLOC && !kernel_request &&
          (owner_id == gfa_pkg::TAG_FREE || owner_id == gfa_pkg::TAG_KERNEL)) begin
        res_status <= gfa_pkg::ST_NONE;
      end else if ((action == gfa_pkg::ACT_FREE || action == gfa_pkg::ACT_QUERY) &&
                   !in_range) begin
        res_status <= gfa_pkg::ST_RANGE;
      end else begin
        res_status <= gfa_pkg::ST_OK;
      end
    end
    // Slide the neighbour window with each scan read.
    if (state == S_SCAN && rd_vld) begin
      w0 <= w1;
      w1 <= rd_data;
    end
    if (grant) begin
      res_grant <= 14'(cand);
      res_tag   <= req_tag;
    end else if (state == S_FLUSH) begin
      res_status <= gfa_pkg::ST_NONE;
    end
    if (state == S_QWAIT && rd_vld) begin
      res_tag <= rd_data;
    end
    if (state == S_RESP && out_free) begin
      status        <= res_status;
      granted_frame <= res_grant;
      owner_tag     <= res_tag;
    end
  end

  // Checks
  a_no_beat_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !out_valid)
    else $error("result beat during clearing pass");

  a_accept_starts_work: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("input taken again before the item finished");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == gfa_pkg::ST_OK || status == gfa_pkg::ST_NONE ||
                   status == gfa_pkg::ST_RANGE))
    else $error("undefined status code");

  a_grant_single_write: assert property (@(posedge clk) disable iff (rst)
    grant |=> (state == S_RESP) && !wr_en)
    else $error("grant not followed by result");

endmodule

`default_nettype wire
